@@ hdl/sgdm_pkg.sv @@
// shared constants, types and helpers for the momentum update core
`default_nettype none

package sgdm_pkg;

    localparam int NumElems  = 1024;
    localparam int IdxW      = $clog2(NumElems);
    localparam int DataW     = 32;
    localparam int CoefW     = 16;
    localparam int CfgIdxW   = 2;
    localparam int SatInW    = 36;
    localparam int RoundHalf = 32'h0000_8000;

    // command codes
    localparam logic CmdLoad   = 1'b0;
    localparam logic CmdUpdate = 1'b1;

    // register indexes
    localparam logic [CfgIdxW-1:0] CfgMomentumCoeff = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgWeightDecay   = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgNesterovMode  = 2'd2;

    // fields that ride along with every request
    typedef struct packed {
        logic                    cmd;
        logic [IdxW-1:0]         idx;
        logic signed [DataW-1:0] value;
    } req_ctl_t;

    // clamp to signed 32 bits
    function automatic logic signed [DataW-1:0] sat32(input logic signed [SatInW-1:0] x);
        logic signed [SatInW-1:0] max_v;
        logic signed [SatInW-1:0] min_v;
        max_v = SatInW'(32'sh7FFF_FFFF);
        min_v = -max_v - SatInW'(1);
        if (x > max_v) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (x < min_v) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = x[DataW-1:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ hdl/sgd_momentum_update_core.sv @@
// sgd with momentum / nesterov update core: six-stage pipeline over two element stores
// a request enters stage one at the accepting edge, then moves through stage registers two to six
//   and the output register before its result is valid
// throughput: one request per cycle unless m_ready stalls the pipeline; a request whose index
//   matches one still in the six stages waits for its write-back (read-after-write on the stores)
// reset: synchronous active-low aresetn clears control and config; afterwards the momentum
//   store is cleared entry by entry over all 1024 entries, during which no request is accepted
`default_nettype none

module sgd_momentum_update_core
    import sgdm_pkg::*;
(
    input  wire                       aclk,
    input  wire                       aresetn,
    // configuration write port
    input  wire                       cfg_wr_en,
    input  wire  [CfgIdxW-1:0]        cfg_index,
    input  wire  [CoefW-1:0]          cfg_wdata,
    // request channel
    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire                       s_cmd,
    input  wire  [IdxW-1:0]           s_elem_index,
    input  wire  signed [DataW-1:0]   s_value,
    input  wire  [CoefW-1:0]          s_learning_rate,
    // result channel
    output logic                      m_valid,
    input  wire                       m_ready,
    output logic [IdxW-1:0]           m_out_index,
    output logic signed [DataW-1:0]   m_new_param
);

    localparam int ProdW  = DataW + CoefW + 1;   // 16u x 32s product
    localparam int VSumW  = ProdW + 2;           // three products and rounding bias
    localparam int NSumW  = ProdW + 1;           // two products and rounding bias
    localparam int NestW  = NSumW - CoefW;

    // configuration registers
    logic [CoefW-1:0] mu_reg;
    logic [CoefW-1:0] decay_reg;
    logic             nesterov_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_reg       <= '0;
            decay_reg    <= '0;
            nesterov_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CfgMomentumCoeff: mu_reg       <= cfg_wdata;
                CfgWeightDecay:   decay_reg    <= cfg_wdata;
                CfgNesterovMode:  nesterov_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // momentum store clearing pass after reset
    logic [IdxW:0] clr_cnt_reg;
    logic          clr_done;

    assign clr_done = clr_cnt_reg[IdxW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (!clr_done) begin
            clr_cnt_reg <= clr_cnt_reg + (IdxW+1)'(1);
        end
    end

    // pipeline valid bits and stage enables
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic out_valid_reg;
    logic en_out, en6, en5, en4, en3, en2, en1;
    logic accept;
    logic hazard;
    logic wb;

    // a stage moves on when it is empty or its successor moves on
    assign en_out = !out_valid_reg || m_ready;
    assign en6    = !s6_valid_reg || en_out;
    assign en5    = !s5_valid_reg || en6;
    assign en4    = !s4_valid_reg || en5;
    assign en3    = !s3_valid_reg || en4;
    assign en2    = !s2_valid_reg || en3;
    assign en1    = !s1_valid_reg || en2;

    // stage payloads
    req_ctl_t s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg, s5_ctl_reg, s6_ctl_reg;

    // same index still in flight: its write-back has not landed yet
    assign hazard = (s1_valid_reg && s1_ctl_reg.idx == s_elem_index)
                 || (s2_valid_reg && s2_ctl_reg.idx == s_elem_index)
                 || (s3_valid_reg && s3_ctl_reg.idx == s_elem_index)
                 || (s4_valid_reg && s4_ctl_reg.idx == s_elem_index)
                 || (s5_valid_reg && s5_ctl_reg.idx == s_elem_index)
                 || (s6_valid_reg && s6_ctl_reg.idx == s_elem_index);

    assign s_ready = en1 && clr_done && !hazard;
    assign accept  = s_valid && s_ready;
    assign wb      = s6_valid_reg && en_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en1)    s1_valid_reg  <= accept;
            if (en2)    s2_valid_reg  <= s1_valid_reg;
            if (en3)    s3_valid_reg  <= s2_valid_reg;
            if (en4)    s4_valid_reg  <= s3_valid_reg;
            if (en5)    s5_valid_reg  <= s4_valid_reg;
            if (en6)    s6_valid_reg  <= s5_valid_reg;
            if (en_out) out_valid_reg <= s6_valid_reg;
        end
    end

    // element stores, one read and one write port each
    logic signed [DataW-1:0] param_mem [NumElems];
    logic signed [DataW-1:0] mom_mem   [NumElems];
    logic signed [DataW-1:0] p_rd_reg;
    logic signed [DataW-1:0] m_rd_reg;

    logic signed [DataW-1:0] result_w;
    logic signed [DataW-1:0] mom_wdata;
    logic                    mom_we;

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_rd_reg <= param_mem[s_elem_index];
        end
        if (wb) begin
            param_mem[s6_ctl_reg.idx] <= result_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_rd_reg <= mom_mem[s_elem_index];
        end
        if (!clr_done) begin
            mom_mem[clr_cnt_reg[IdxW-1:0]] <= '0;
        end else if (mom_we) begin
            mom_mem[s6_ctl_reg.idx] <= mom_wdata;
        end
    end

    // stage 1: request registered, store words arrive; form lr*decay and lr*g
    logic [CoefW-1:0]        s1_lr_reg;
    logic [2*CoefW-1:0]      lrwd_w;
    logic [2*CoefW:0]        ld_sum_w;
    logic signed [ProdW-1:0] lrg_w;

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_ctl_reg <= '{cmd: s_cmd, idx: s_elem_index, value: s_value};
            s1_lr_reg  <= s_learning_rate;
        end
    end

    assign lrwd_w   = (2*CoefW)'(s1_lr_reg) * (2*CoefW)'(decay_reg);
    // lr*decay rounded half up to q0.16
    assign ld_sum_w = (2*CoefW+1)'(lrwd_w) + (2*CoefW+1)'(RoundHalf);
    assign lrg_w    = ProdW'($signed({1'b0, s1_lr_reg})) * ProdW'($signed(s1_ctl_reg.value));

    // stage 2: decay and momentum products
    logic [CoefW-1:0]        s2_ld_reg;
    logic signed [ProdW-1:0] s2_lrg_reg;
    logic signed [DataW-1:0] s2_p_reg;
    logic signed [DataW-1:0] s2_m_reg;
    logic signed [ProdW-1:0] ldp_w;
    logic signed [ProdW-1:0] mum_w;

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_ctl_reg <= s1_ctl_reg;
            s2_ld_reg  <= ld_sum_w[2*CoefW-1:CoefW];
            s2_lrg_reg <= lrg_w;
            s2_p_reg   <= p_rd_reg;
            s2_m_reg   <= m_rd_reg;
        end
    end

    assign ldp_w = ProdW'($signed({1'b0, s2_ld_reg})) * ProdW'(s2_p_reg);
    assign mum_w = ProdW'($signed({1'b0, mu_reg})) * ProdW'(s2_m_reg);

    // stage 3: velocity sum, rounded and clamped (mu of zero drops the momentum term)
    logic signed [ProdW-1:0] s3_lrg_reg;
    logic signed [ProdW-1:0] s3_ldp_reg;
    logic signed [ProdW-1:0] s3_mum_reg;
    logic signed [DataW-1:0] s3_p_reg;
    logic signed [VSumW-1:0] vsum_w;
    logic signed [DataW-1:0] v_w;

    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_ctl_reg <= s2_ctl_reg;
            s3_lrg_reg <= s2_lrg_reg;
            s3_ldp_reg <= ldp_w;
            s3_mum_reg <= mum_w;
            s3_p_reg   <= s2_p_reg;
        end
    end

    assign vsum_w = VSumW'(s3_mum_reg) - VSumW'(s3_lrg_reg) - VSumW'(s3_ldp_reg)
                  + VSumW'(RoundHalf);
    assign v_w    = sat32(SatInW'(vsum_w >>> CoefW));

    // stage 4: mu * v for the look-ahead step
    logic signed [ProdW-1:0] s4_lrg_reg;
    logic signed [DataW-1:0] s4_p_reg;
    logic signed [DataW-1:0] s4_v_reg;
    logic signed [ProdW-1:0] muv_w;

    always_ff @(posedge aclk) begin
        if (en4) begin
            s4_ctl_reg <= s3_ctl_reg;
            s4_lrg_reg <= s3_lrg_reg;
            s4_p_reg   <= s3_p_reg;
            s4_v_reg   <= v_w;
        end
    end

    assign muv_w = ProdW'($signed({1'b0, mu_reg})) * ProdW'(s4_v_reg);

    // stage 5: look-ahead step mu*v - lr*g rounded to q16.16
    logic signed [ProdW-1:0] s5_lrg_reg;
    logic signed [ProdW-1:0] s5_muv_reg;
    logic signed [DataW-1:0] s5_p_reg;
    logic signed [DataW-1:0] s5_v_reg;
    logic signed [NSumW-1:0] nsum_w;

    always_ff @(posedge aclk) begin
        if (en5) begin
            s5_ctl_reg <= s4_ctl_reg;
            s5_lrg_reg <= s4_lrg_reg;
            s5_muv_reg <= muv_w;
            s5_p_reg   <= s4_p_reg;
            s5_v_reg   <= s4_v_reg;
        end
    end

    assign nsum_w = NSumW'(s5_muv_reg) - NSumW'(s5_lrg_reg) + NSumW'(RoundHalf);

    // stage 6: new parameter, write-back to both stores (momentum kept on updates with mu zero)
    logic signed [NestW-1:0] s6_nest_reg;
    logic signed [DataW-1:0] s6_p_reg;
    logic signed [DataW-1:0] s6_v_reg;
    logic signed [SatInW-1:0] upd_sum_w;

    always_ff @(posedge aclk) begin
        if (en6) begin
            s6_ctl_reg  <= s5_ctl_reg;
            s6_nest_reg <= NestW'(nsum_w >>> CoefW);
            s6_p_reg    <= s5_p_reg;
            s6_v_reg    <= s5_v_reg;
        end
    end

    always_comb begin
        if (nesterov_reg) begin
            upd_sum_w = SatInW'(s6_p_reg) + SatInW'(s6_nest_reg);
        end else begin
            upd_sum_w = SatInW'(s6_p_reg) + SatInW'(s6_v_reg);
        end
        if (s6_ctl_reg.cmd == CmdLoad) begin
            // load writes the parameter and clears its momentum
            result_w  = s6_ctl_reg.value;
            mom_wdata = '0;
            mom_we    = wb;
        end else begin
            result_w  = sat32(upd_sum_w);
            mom_wdata = s6_v_reg;
            mom_we    = wb && (mu_reg != '0);
        end
    end

    // output register
    logic [IdxW-1:0]         out_idx_reg;
    logic signed [DataW-1:0] out_param_reg;

    always_ff @(posedge aclk) begin
        if (en_out) begin
            out_idx_reg   <= s6_ctl_reg.idx;
            out_param_reg <= result_w;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_index = out_idx_reg;
    assign m_new_param = out_param_reg;

endmodule

`default_nettype wire

@@ tb/tb_sgd_momentum_update_core.sv @@
// self-checking testbench for the sgd momentum / nesterov update core
`timescale 1ns / 100ps

module tb_sgd_momentum_update_core
    import sgdm_pkg::*;
();

    localparam int ClkPeriod     = 4;
    localparam int ResetCycles   = 5;
    // margin after the last result before touching config
    localparam int DrainCycles   = 10;
    localparam int MaxGap        = 12;
    localparam int LongHold      = 200;
    // watchdog limit, to outlast the clearing pass after reset and the long hold
    localparam int StallLimit    = 4000;
    localparam int NumPhases     = 7;
    localparam int ItemsPerPhase = 100;
    localparam int HoldPhase     = 2;
    localparam int QuietPhase    = 1;
    localparam int MaxReports    = 10;

    typedef enum logic {RowRequest, RowConfig} row_kind_t;

    // one line of the directed table: either a request or a full config set
    typedef struct {
        row_kind_t               kind;
        logic                    cmd;
        logic [IdxW-1:0]         idx;
        logic signed [DataW-1:0] value;
        logic [CoefW-1:0]        rate;
        bit                      has_exp;
        logic signed [DataW-1:0] exp_param;
        logic [CoefW-1:0]        mu;
        logic [CoefW-1:0]        decay;
        logic                    nesterov;
    } stim_row_t;

    typedef struct packed {
        logic [IdxW-1:0]         idx;
        logic signed [DataW-1:0] param;
    } param_result_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CfgIdxW-1:0]      cfg_index;
    logic [CoefW-1:0]        cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_cmd;
    logic [IdxW-1:0]         s_elem_index;
    logic signed [DataW-1:0] s_value;
    logic [CoefW-1:0]        s_learning_rate;
    logic                    m_valid;
    logic                    m_ready;
    logic [IdxW-1:0]         m_out_index;
    logic signed [DataW-1:0] m_new_param;

    // predictor state: own copy of both element stores and the config
    logic signed [DataW-1:0] param_mem [NumElems];
    logic signed [DataW-1:0] mom_mem [NumElems];
    logic [CoefW-1:0]        cur_momentum_coeff;
    logic [CoefW-1:0]        cur_weight_decay;
    logic                    cur_nesterov;

    // elements that have seen a load; updates only ever target these
    bit                      elem_loaded [NumElems];
    int unsigned             loaded_list[$];

    param_result_t           pending_params[$];
    stim_row_t               directed_rows[$];

    // knobs shared between the stimulus, the receiver and the main sequence
    bit                      tx_idle_en;
    bit                      rx_idle_en;
    int unsigned             rx_hold_cycles;

    int unsigned             mismatch_count;
    int unsigned             checked_count;
    int unsigned             load_count;
    int unsigned             update_count;
    int unsigned             settings_count;
    int unsigned             quiet_cycles;

    sgd_momentum_update_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_elem_index    (s_elem_index),
        .s_value         (s_value),
        .s_learning_rate (s_learning_rate),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_index     (m_out_index),
        .m_new_param     (m_new_param)
    );

    always begin
        aclk = 1'b0;
        #(ClkPeriod / 2);
        aclk = 1'b1;
        #(ClkPeriod / 2);
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic logic signed [DataW-1:0] clamp_word(input longint x);
        if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return DataW'(x);
    endfunction

    // q16.32 down to q16.16, round half up (floor after adding half an lsb)
    function automatic longint round_q16(input longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    // new parameter of one request, updating the predictor's stores
    function automatic logic signed [DataW-1:0] advance_param(
        input logic                    cmd,
        input logic [IdxW-1:0]         idx,
        input logic signed [DataW-1:0] val,
        input logic [CoefW-1:0]        lr
    );
        longint cur_p;
        longint grad;
        longint rate;
        longint mu_l;
        longint mom_l;
        longint lr_decay;
        longint lr_grad;
        longint vel;
        longint updated;
        if (cmd == CmdLoad) begin
            param_mem[idx] = val;
            mom_mem[idx]   = '0;
            return val;
        end
        cur_p    = longint'(param_mem[idx]);
        grad     = longint'(val);
        rate     = longint'(lr);
        mu_l     = longint'(cur_momentum_coeff);
        mom_l    = longint'(mom_mem[idx]);
        // lr*decay rounded to q0.16 before it meets the parameter
        lr_decay = (rate * longint'(cur_weight_decay) + 64'sd32768) >>> 16;
        lr_grad  = rate * grad;
        if (mu_l == 0) begin
            // momentum store left alone when mu is zero
            vel = longint'(clamp_word(round_q16(-lr_grad - lr_decay * cur_p)));
        end else begin
            vel = longint'(clamp_word(round_q16(mu_l * mom_l - lr_grad - lr_decay * cur_p)));
            mom_mem[idx] = DataW'(vel);
        end
        if (cur_nesterov) begin
            // look-ahead step; with mu zero this collapses to p - lr*g
            updated = longint'(clamp_word(cur_p + round_q16(mu_l * vel - lr_grad)));
        end else begin
            updated = longint'(clamp_word(cur_p + vel));
        end
        param_mem[idx] = DataW'(updated);
        return DataW'(updated);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic void add_request(
        input logic                    cmd,
        input logic [IdxW-1:0]         idx,
        input logic signed [DataW-1:0] val,
        input logic [CoefW-1:0]        lr,
        input bit                      has_exp,
        input logic signed [DataW-1:0] exp_param
    );
        stim_row_t row;
        row           = '{kind: RowRequest, default: '0};
        row.cmd       = cmd;
        row.idx       = idx;
        row.value     = val;
        row.rate      = lr;
        row.has_exp   = has_exp;
        row.exp_param = exp_param;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_config(
        input logic [CoefW-1:0] mu,
        input logic [CoefW-1:0] decay,
        input logic             nesterov
    );
        stim_row_t row;
        row          = '{kind: RowConfig, default: '0};
        row.mu       = mu;
        row.decay    = decay;
        row.nesterov = nesterov;
        directed_rows.push_back(row);
    endfunction

    // extremes, full-range noise, and half the time values small enough to keep
    // parameters out of saturation
    function automatic logic signed [DataW-1:0] random_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [CoefW-1:0] random_rate();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return CoefW'($urandom_range(0, 16'hFFFF));
            default: return CoefW'($urandom_range(0, 16'h1000));
        endcase
    endfunction

    // offer one request after a random gap if tx_idle_en, and log its expected result
    task automatic send_request(
        input logic                    cmd,
        input logic [IdxW-1:0]         idx,
        input logic signed [DataW-1:0] val,
        input logic [CoefW-1:0]        lr,
        input bit                      has_exp,
        input logic signed [DataW-1:0] exp_param
    );
        int unsigned   gap;
        param_result_t res;
        gap = tx_idle_en ? $urandom_range(0, MaxGap) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= cmd;
        s_elem_index    <= idx;
        s_value         <= val;
        s_learning_rate <= lr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // request taken at this edge
        res.idx   = idx;
        res.param = advance_param(cmd, idx, val, lr);
        // typed rows carry their own expectation, which overrides the predictor
        if (has_exp) res.param = exp_param;
        pending_params.push_back(res);
        if (cmd == CmdLoad) begin
            load_count++;
            if (!elem_loaded[idx]) begin
                elem_loaded[idx] = 1'b1;
                loaded_list.push_back(32'(idx));
            end
        end else begin
            update_count++;
        end
        @(negedge aclk);
    endtask

    // stop offering and let every outstanding request come back
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_params.size() != 0) @(negedge aclk);
        repeat (DrainCycles) @(negedge aclk);
    endtask

    // write all three registers back to back; only called with the core idle
    task automatic write_config(
        input logic [CoefW-1:0] mu,
        input logic [CoefW-1:0] decay,
        input logic             nesterov
    );
        cfg_wr_en <= 1'b1;
        cfg_index <= CfgMomentumCoeff;
        cfg_wdata <= mu;
        @(negedge aclk);
        cfg_index <= CfgWeightDecay;
        cfg_wdata <= decay;
        @(negedge aclk);
        cfg_index <= CfgNesterovMode;
        cfg_wdata <= CoefW'(nesterov);
        @(negedge aclk);
        cfg_wr_en          <= 1'b0;
        cur_momentum_coeff = mu;
        cur_weight_decay   = decay;
        cur_nesterov       = nesterov;
        settings_count++;
    endtask

    task automatic flag_mismatch(
        input string             what,
        input logic [DataW-1:0]  exp_v,
        input logic [DataW-1:0]  got_v
    );
        mismatch_count++;
        if (mismatch_count <= MaxReports)
            $display("%0t: %s: expected %h, got %h", $realtime, what, exp_v, got_v);
    endtask

    // ------------------------------------------------------------------
    // result side: random back-pressure plus one long hold when asked
    // ------------------------------------------------------------------

    initial begin
        int unsigned wait_cycles;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (rx_hold_cycles != 0) begin
                // long hold so the pipeline backs up into the request side
                wait_cycles    = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                wait_cycles = rx_idle_en ? $urandom_range(0, MaxGap) : 0;
            end
            if (wait_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // compare every result against the oldest expectation
    always @(posedge aclk) begin
        param_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_params.size() == 0) begin
                flag_mismatch("result with nothing outstanding", '0, m_new_param);
            end else begin
                exp_r = pending_params.pop_front();
                checked_count++;
                if (m_out_index !== exp_r.idx)
                    flag_mismatch("out_index", DataW'(exp_r.idx), DataW'(m_out_index));
                if (m_new_param !== exp_r.param)
                    flag_mismatch($sformatf("new_param of element %0d", exp_r.idx),
                                  exp_r.param, m_new_param);
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == StallLimit) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        int unsigned     sent;
        int unsigned     k;
        bit              fwd;
        logic [IdxW-1:0] idx;
        logic [CoefW-1:0] pass_rate;
        logic [CoefW-1:0] mu;
        int unsigned     batch[$];

        aresetn            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = CfgMomentumCoeff;
        cfg_wdata          = '0;
        s_valid            = 1'b0;
        s_cmd              = CmdLoad;
        s_elem_index       = '0;
        s_value            = '0;
        s_learning_rate    = '0;
        cur_momentum_coeff = '0;
        cur_weight_decay   = '0;
        cur_nesterov       = 1'b0;
        tx_idle_en         = 1'b1;
        rx_idle_en         = 1'b1;
        rx_hold_cycles     = 0;
        mismatch_count     = 0;
        checked_count      = 0;
        load_count         = 0;
        update_count       = 0;
        settings_count     = 1;
        quiet_cycles       = 0;
        foreach (mom_mem[i]) mom_mem[i] = '0;
        foreach (param_mem[i]) param_mem[i] = '0;

        // directed table; register defaults after reset are mu 0, decay 0, plain
        add_request(CmdLoad, 10'd0, 32'sh7FFF_FFFF, 16'hFFFF, 1'b1, 32'sh7FFF_FFFF);
        add_request(CmdLoad, 10'd1023, 32'sh8000_0000, 16'h0000, 1'b1, 32'sh8000_0000);
        add_request(CmdLoad, 10'd5, 32'sh0000_0000, 16'h1234, 1'b1, 32'sh0000_0000);
        // largest step on top of the largest parameter saturates high
        add_request(CmdUpdate, 10'd0, 32'sh8000_0000, 16'hFFFF, 1'b1, 32'sh7FFF_FFFF);
        // and the mirror image saturates low
        add_request(CmdUpdate, 10'd1023, 32'sh7FFF_FFFF, 16'hFFFF, 1'b1, 32'sh8000_0000);
        // zero learning rate leaves the parameter alone
        add_request(CmdUpdate, 10'd5, 32'sh0000_0000, 16'h0000, 1'b1, 32'sh0000_0000);
        // 0.5 * 1.0 step
        add_request(CmdUpdate, 10'd5, 32'sh0001_0000, 16'h8000, 1'b1, 32'shFFFF_8000);
        // exactly half an lsb, rounds up
        add_request(CmdUpdate, 10'd5, 32'shFFFF_FFFF, 16'h8000, 1'b0, '0);
        // full momentum and decay
        add_config(16'hFFFF, 16'hFFFF, 1'b0);
        add_request(CmdLoad, 10'd7, 32'sh0002_0000, 16'h0000, 1'b0, '0);
        add_request(CmdUpdate, 10'd7, 32'sh0000_1000, 16'h4000, 1'b0, '0);
        add_request(CmdUpdate, 10'd7, 32'sh0000_1000, 16'h4000, 1'b0, '0);
        add_request(CmdUpdate, 10'd7, 32'shFFFF_0000, 16'hFFFF, 1'b0, '0);
        add_request(CmdUpdate, 10'd0, 32'sh8000_0000, 16'hFFFF, 1'b0, '0);
        // nesterov with momentum at its largest
        add_config(16'hFFFF, 16'hFFFF, 1'b1);
        add_request(CmdUpdate, 10'd7, 32'sh0001_0000, 16'hFFFF, 1'b0, '0);
        add_request(CmdUpdate, 10'd1023, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0, '0);
        // nesterov with zero mu: decay never reaches the parameter
        add_config(16'h0000, 16'h8000, 1'b1);
        add_request(CmdUpdate, 10'd7, 32'sh0000_8000, 16'h1000, 1'b0, '0);
        add_request(CmdUpdate, 10'd5, 32'sh0003_0000, 16'hFFFF, 1'b0, '0);
        // reload clears the momentum of that element
        add_request(CmdLoad, 10'd7, 32'shFFFF_FFFF, 16'hFFFF, 1'b0, '0);
        add_config(16'h8000, 16'h0000, 1'b0);
        add_request(CmdUpdate, 10'd7, 32'sh0003_0000, 16'h2000, 1'b0, '0);
        add_request(CmdUpdate, 10'd7, 32'shFFFD_0000, 16'h2000, 1'b0, '0);

        repeat (ResetCycles) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == RowConfig) begin
                drain_pipeline();
                write_config(directed_rows[i].mu, directed_rows[i].decay,
                             directed_rows[i].nesterov);
            end else begin
                send_request(directed_rows[i].cmd, directed_rows[i].idx,
                             directed_rows[i].value, directed_rows[i].rate,
                             directed_rows[i].has_exp, directed_rows[i].exp_param);
            end
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < NumPhases; ph++) begin
            drain_pipeline();
            if (ph == QuietPhase) begin
                write_config('0, '0, 1'b0);
            end else if (ph == HoldPhase) begin
                write_config('1, '1, 1'b1);
            end else begin
                mu = ($urandom_range(0, 3) == 0) ? '0 : CoefW'($urandom_range(1, 16'hFFFF));
                write_config(mu, CoefW'($urandom_range(0, 16'hFFFF)),
                             1'($urandom_range(0, 1)));
            end
            // one phase runs flat out on both sides, one backs the core up
            tx_idle_en = (ph != QuietPhase) && (ph != HoldPhase);
            rx_idle_en = (ph != QuietPhase);
            if (ph == HoldPhase) rx_hold_cycles = LongHold;

            sent = 0;
            while (sent < ItemsPerPhase) begin
                if ($urandom_range(0, 4) != 0) begin
                    // training-style sequence: load a batch, then a few passes
                    // of gradients over it, one learning rate per pass
                    batch.delete();
                    repeat ($urandom_range(2, 10)) begin
                        idx = IdxW'($urandom_range(0, NumElems - 1));
                        batch.push_back(32'(idx));
                        send_request(CmdLoad, idx, random_value(), random_rate(), 1'b0, '0);
                        sent++;
                    end
                    repeat ($urandom_range(1, 4)) begin
                        pass_rate = random_rate();
                        fwd       = ($urandom_range(0, 1) != 0);
                        foreach (batch[j]) begin
                            // walk the batch either way round
                            k = fwd ? j : batch.size() - 1 - j;
                            send_request(CmdUpdate, IdxW'(batch[k]), random_value(),
                                         pass_rate, 1'b0, '0);
                            sent++;
                            // back-to-back hits on one element exercise the hazard stall
                            if ($urandom_range(0, 5) == 0) begin
                                send_request(CmdUpdate, IdxW'(batch[k]), random_value(),
                                             pass_rate, 1'b0, '0);
                                sent++;
                            end
                        end
                    end
                end else if ($urandom_range(0, 1) != 0) begin
                    // stray update on anything already loaded
                    idx = IdxW'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
                    send_request(CmdUpdate, idx, random_value(), random_rate(), 1'b0, '0);
                    sent++;
                end else begin
                    // stray load anywhere
                    idx = IdxW'($urandom_range(0, NumElems - 1));
                    send_request(CmdLoad, idx, random_value(), random_rate(), 1'b0, '0);
                    sent++;
                end
            end
        end

        drain_pipeline();

        $display("covered %0d requests (%0d loads, %0d updates) over %0d register settings",
                 load_count + update_count, load_count, update_count, settings_count);
        $display("%0d results compared, %0d mismatches, %0d elements touched",
                 checked_count, mismatch_count, loaded_list.size());
        if (mismatch_count == 0 && pending_params.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
